### hdl/tea_xtea_xxtea_block_cipher_core_defines.svh
// Assertion macros used by the checker file.
`ifndef TEA_XTEA_XXTEA_BLOCK_CIPHER_CORE_DEFINES_SVH
`define TEA_XTEA_XXTEA_BLOCK_CIPHER_CORE_DEFINES_SVH

// Implication checked at every edge outside reset.
`define TXC_ASSERT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication checked at every edge, reset included.
`define TXC_ASSERT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

### hdl/txc_pkg.sv
package txc_pkg;

   typedef logic [31:0] word_type;

   typedef enum logic [1:0] {
      ALG_XOR   = 2'd0,
      ALG_TEA   = 2'd1,
      ALG_XTEA  = 2'd2,
      ALG_XXTEA = 2'd3
   } alg_type;

   typedef enum logic [1:0] {
      REG_KEY  = 2'd0,
      REG_ALG  = 2'd1,
      REG_DIR  = 2'd2,
      REG_NONE = 2'd3
   } reg_index_type;

   localparam word_type DELTA = 32'h9E37_79B9;

   typedef struct packed {
      word_type v0;
      word_type v1;
      word_type sum;
   } round_type;

   function automatic word_type tea_f(word_type v, word_type s, word_type ka, word_type kb);
      return ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
   endfunction

   function automatic word_type xtea_g(word_type v);
      return ((v << 4) ^ (v >> 5)) + v;
   endfunction

   // The 128-bit key repeats k0,k1, so only bit 0 of a key index matters.
   function automatic word_type key_pick(logic sel, word_type k0, word_type k1);
      return sel ? k1 : k0;
   endfunction

   function automatic word_type xxtea_mix(word_type y, word_type s, logic p,
                                          word_type k0, word_type k1);
      word_type kk;
      kk = key_pick(p ^ s[2], k0, k1);
      return (((y >> 5) ^ (y << 2)) + ((y >> 3) ^ (y << 4))) ^ ((s ^ y) + (kk ^ y));
   endfunction

   // One half round: an even step updates one word, an odd step the other.
   function automatic round_type half_round(alg_type alg, logic dec, logic odd,
                                            word_type v0, word_type v1, word_type sum,
                                            word_type k0, word_type k1);
      round_type r;
      word_type s;
      r = '{v0: v0, v1: v1, sum: sum};
      s = sum + DELTA;
      case (alg)
         ALG_TEA: begin
            if (!dec) begin
               if (!odd) begin
                  r.sum = s;
                  r.v0  = v0 + tea_f(v1, s, k0, k1);
               end else begin
                  r.v1 = v1 + tea_f(v0, sum, k0, k1);
               end
            end else begin
               if (!odd) begin
                  r.v1 = v1 - tea_f(v0, sum, k0, k1);
               end else begin
                  r.v0  = v0 - tea_f(v1, sum, k0, k1);
                  r.sum = sum - DELTA;
               end
            end
         end
         ALG_XTEA: begin
            if (!dec) begin
               if (!odd) begin
                  r.v0  = v0 + (xtea_g(v1) ^ (sum + key_pick(sum[0], k0, k1)));
                  r.sum = s;
               end else begin
                  r.v1 = v1 + (xtea_g(v0) ^ (sum + key_pick(sum[11], k0, k1)));
               end
            end else begin
               if (!odd) begin
                  r.v1  = v1 - (xtea_g(v0) ^ (sum + key_pick(sum[11], k0, k1)));
                  r.sum = sum - DELTA;
               end else begin
                  r.v0 = v0 - (xtea_g(v1) ^ (sum + key_pick(sum[0], k0, k1)));
               end
            end
         end
         ALG_XXTEA: begin
            if (!dec) begin
               if (!odd) begin
                  r.sum = s;
                  r.v0  = v0 + xxtea_mix(v1, s, 1'b0, k0, k1);
               end else begin
                  r.v1 = v1 + xxtea_mix(v0, sum, 1'b1, k0, k1);
               end
            end else begin
               if (!odd) begin
                  r.v1 = v1 - xxtea_mix(v0, sum, 1'b1, k0, k1);
               end else begin
                  r.v0  = v0 - xxtea_mix(v1, sum, 1'b0, k0, k1);
                  r.sum = sum - DELTA;
               end
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

endpackage

### hdl/txc_req_if.sv
interface txc_req_if (input logic clock);
   logic        valid;
   logic        ready;
   logic [63:0] block_in;
   modport source (output valid, output block_in, input ready);
   modport sink (input valid, input block_in, output ready);
endinterface

### hdl/txc_rsp_if.sv
interface txc_rsp_if (input logic clock);
   logic        valid;
   logic        ready;
   logic [63:0] block_out;
   modport source (output valid, output block_out, input ready);
   modport sink (input valid, input block_out, output ready);
endinterface

### hdl/tea_xtea_xxtea_block_cipher_core.sv
// TEA, XTEA and XXTEA (two words) block cipher, plus a plain key XOR mode, on 64-bit
// beats. Every half round has its own register stage, so the pipeline holds
// 2*max(TEA_CYCLES, XTEA_CYCLES, XXTEA_ROUNDS)+1 stages (65 by default) and takes one
// beat per clock while the skid register is empty. A beat accepted by the core passes
// through every stage to the output, whatever the algorithm. A one-beat skid register
// at the output lets the core take one more beat while a result waits. Key, algorithm
// and direction are written over the APB port at byte addresses 0, 8 and 16 and must
// only be changed while the pipeline is empty.
module tea_xtea_xxtea_block_cipher_core #(
   parameter int TEA_CYCLES   = 32,
   parameter int XTEA_CYCLES  = 7,
   parameter int XXTEA_ROUNDS = 32
) (
   input  logic        clock,
   input  logic        reset,
   txc_req_if.sink     req_bus,
   txc_rsp_if.source   rsp_bus,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import txc_pkg::*;

   localparam int MAXN   = (TEA_CYCLES > XTEA_CYCLES) ?
                           ((TEA_CYCLES > XXTEA_ROUNDS) ? TEA_CYCLES : XXTEA_ROUNDS) :
                           ((XTEA_CYCLES > XXTEA_ROUNDS) ? XTEA_CYCLES : XXTEA_ROUNDS);
   localparam int STAGES = 2 * MAXN;
   localparam int CW     = $clog2(STAGES + 1);
   localparam word_type TEA_SUM0   = 32'(64'(DELTA) * 64'(TEA_CYCLES));
   localparam word_type XTEA_SUM0  = 32'(64'(DELTA) * 64'(XTEA_CYCLES));
   localparam word_type XXTEA_SUM0 = 32'(64'(DELTA) * 64'(XXTEA_ROUNDS));

   logic [63:0] key_ff;
   alg_type     alg_ff;
   logic        dir_ff;
   logic        wr_en;
   reg_index_type wr_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign wr_idx     = reg_index_type'(csr_paddr[4:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
         alg_ff <= ALG_TEA;
         dir_ff <= 1'b0;
      end else if (wr_en) begin
         case (wr_idx)
            REG_KEY: key_ff <= csr_pwdata;
            REG_ALG: alg_ff <= alg_type'(csr_pwdata[1:0]);
            REG_DIR: dir_ff <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (wr_idx)
         REG_KEY: csr_prdata = key_ff;
         REG_ALG: csr_prdata = {62'd0, alg_ff};
         REG_DIR: csr_prdata = {63'd0, dir_ff};
         default: csr_prdata = '0;
      endcase
   end

   word_type       k0, k1, sum_init;
   logic [CW-1:0]  half_cnt;

   assign k0 = key_ff[31:0];
   assign k1 = key_ff[63:32];

   always_comb begin
      case (alg_ff)
         ALG_TEA:   begin half_cnt = CW'(2 * TEA_CYCLES);   sum_init = TEA_SUM0;   end
         ALG_XTEA:  begin half_cnt = CW'(2 * XTEA_CYCLES);  sum_init = XTEA_SUM0;  end
         ALG_XXTEA: begin half_cnt = CW'(2 * XXTEA_ROUNDS); sum_init = XXTEA_SUM0; end
         default:   begin half_cnt = '0;                    sum_init = '0;         end
      endcase
      if (!dir_ff) begin
         sum_init = '0;
      end
   end

   // Stage 0 registers the beat; stage i performs half round i-1.
   logic      vld_ff [STAGES+1];
   round_type st_ff  [STAGES+1];
   logic      advance;
   logic      skid_full_ff, skid_full_in;
   logic [63:0] skid_ff;

   assign advance       = ~skid_full_ff;
   assign req_bus.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_ff[0].v0  <= (alg_ff == ALG_XOR) ? (req_bus.block_in[31:0] ^ k0)
                                             : req_bus.block_in[31:0];
         st_ff[0].v1  <= (alg_ff == ALG_XOR) ? (req_bus.block_in[63:32] ^ k1)
                                             : req_bus.block_in[63:32];
         st_ff[0].sum <= sum_init;
      end
   end

   for (genvar i = 1; i <= STAGES; i++) begin : g_stage
      round_type st_in;
      always_comb begin
         if (CW'(i - 1) < half_cnt) begin
            st_in = half_round(alg_ff, dir_ff, 1'((i - 1) % 2), st_ff[i-1].v0,
                               st_ff[i-1].v1, st_ff[i-1].sum, k0, k1);
         end else begin
            st_in = st_ff[i-1];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (advance) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            st_ff[i] <= st_in;
         end
      end
   end

   // A result not taken moves into the skid register, which then freezes the pipeline.
   always_comb begin
      if (skid_full_ff) begin
         skid_full_in = ~rsp_bus.ready;
      end else begin
         skid_full_in = vld_ff[STAGES] & ~rsp_bus.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
      end else begin
         skid_full_ff <= skid_full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_full_ff) begin
         skid_ff <= {st_ff[STAGES].v1, st_ff[STAGES].v0};
      end
   end

   assign rsp_bus.valid     = skid_full_ff | vld_ff[STAGES];
   assign rsp_bus.block_out = skid_full_ff ? skid_ff : {st_ff[STAGES].v1, st_ff[STAGES].v0};

endmodule

### hdl/txc_checker.sv
`include "tea_xtea_xxtea_block_cipher_core_defines.svh"

module txc_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic csr_pready
);

   logic stalled;
   assign stalled = rsp_valid & ~rsp_ready;

   `TXC_ASSERT(a_rsp_hold, clock, reset, stalled, ##1 rsp_valid)
   `TXC_ASSERT(a_stall_blocks, clock, reset, stalled && $past(stalled), !req_ready)
   `TXC_ASSERT_ALWAYS(a_reset_empty, clock, reset, ##1 (!rsp_valid && req_ready))
   `TXC_ASSERT_ALWAYS(a_pready, clock, 1'b1, csr_pready)

endmodule

bind tea_xtea_xxtea_block_cipher_core txc_checker u_txc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .csr_pready (csr_pready)
);
